// ===== design/m64a_pkg.sv =====
// m64a_pkg: constants, field widths and helper functions for the murmur64a stream hash
// used by m64a_mul and murmur64a_stream_hash; no dependencies
`timescale 1ns / 1ps

package m64a_pkg;

  localparam int unsigned WORD_W   = 64;
  localparam int unsigned HALF_W   = 32;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned IN_TDATA_W  = 104;  // 64 + 4 + 32 bits, padded to bytes
  localparam int unsigned OUT_TDATA_W = 64;

  localparam logic [WORD_W-1:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam int unsigned       MIX_SHIFT = 47;
  localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

  // v ^ (v >> 47)
  function automatic logic [WORD_W-1:0] xor_shift(input logic [WORD_W-1:0] v);
    return v ^ (v >> MIX_SHIFT);
  endfunction

  // keep the low count bytes of a partial word
  function automatic logic [WORD_W-1:0] tail_mask(input logic [COUNT_W-1:0] count);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (COUNT_W'(i) < count) begin
        m[i*8 +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

// ===== design/murmur64a_stream_hash.sv =====
// murmur64a_stream_hash: streaming MurmurHash64A engine, sequencer around one shared multiplier
// depends on m64a_pkg and m64a_mul
`timescale 1ns / 1ps

// MurmurHash64A over a message delivered as little-endian 64-bit words, first byte in bits 7:0.
// The word flagged in tuser (first) loads the hash with hash_seed ^ (total_length * M); a word
// with byte_count 8 or more is mixed in fully, 1 to 7 bytes are masked and folded in, 0 leaves
// the hash alone. The word with tlast set produces one output transfer holding the finalized hash.
// The block takes one word at a time and is not ready while a word is in work. Every 64-bit
// multiply by the constant runs on a single shared 32x32 multiplier: a full word takes three
// multiplies, a tail one and an empty word none, plus one when the word opens a message and
// one when it closes it, and a word is held up while an earlier result still waits. The
// finished hash sits in an output register, so the next word is taken while the result
// waits; a second result waits in the sequencer until the register is free. hash_seed is
// written through cfg_wr_en / cfg_wr_data; the user must write it only while the block is
// idle, as the block itself does not enforce this.

module murmur64a_stream_hash (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_wr_en,
  input  logic [m64a_pkg::WORD_W-1:0]        cfg_wr_data,   // hash_seed
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [m64a_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // data_word[63:0], byte_count[67:64],
                                                            // total_length[99:68], zero pad
  input  logic                               s_axis_tuser,  // first_item
  input  logic                               s_axis_tlast,  // last_item
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [m64a_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // hash_value
);
  import m64a_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,   // waiting for a word
    S_INIT,   // length times constant in flight
    S_BODY,   // pick full, tail or empty word
    S_MIX1,   // k * M in flight
    S_MIX2,   // (k ^ k>>47) * M in flight
    S_HMUL,   // h * M in flight
    S_END,    // word folded in; finalize if last
    S_FIN,    // finalize multiply in flight
    S_EMIT    // result waits for the output register
  } state_t;

  state_t             state;
  logic [WORD_W-1:0]  hash_seed;
  logic [WORD_W-1:0]  running_hash;  // unfinalized hash, kept across messages
  logic [WORD_W-1:0]  word;          // data word, later the final result
  logic [COUNT_W-1:0] count;
  logic               last;

  // shared multiplier
  logic               mul_start;
  logic [WORD_W-1:0]  mul_operand;
  logic               mul_busy;
  logic               mul_done;
  logic [WORD_W-1:0]  mul_product;

  logic               in_xfer;
  logic               out_free;
  logic [WORD_W-1:0]  tail_hash;
  logic [WORD_W-1:0]  mixed;

  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign tail_hash = running_hash ^ (word & tail_mask(count));
  assign mixed     = xor_shift(mul_product);

  // multiplier launch for each step
  always_comb begin
    mul_start   = 1'b0;
    mul_operand = word;
    case (state)
      S_IDLE: begin
        mul_start   = in_xfer && s_axis_tuser;
        mul_operand = WORD_W'(s_axis_tdata[99:68]);
      end
      S_BODY: begin
        if (count >= FULL_COUNT) begin
          mul_start   = 1'b1;
          mul_operand = word;
        end else if (count != '0) begin
          mul_start   = 1'b1;
          mul_operand = tail_hash;
        end
      end
      S_MIX1: begin
        mul_start   = mul_done;
        mul_operand = mixed;
      end
      S_MIX2: begin
        mul_start   = mul_done;
        mul_operand = running_hash ^ mul_product;
      end
      S_END: begin
        mul_start   = last;
        mul_operand = xor_shift(running_hash);
      end
      default: begin
        mul_start   = 1'b0;
        mul_operand = word;
      end
    endcase
  end

  m64a_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .operand (mul_operand),
    .busy    (mul_busy),
    .done    (mul_done),
    .product (mul_product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      hash_seed     <= '0;
      running_hash  <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        hash_seed <= cfg_wr_data;
      end
      // load wins over the drain of the previous transfer
      if (state == S_EMIT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            word   <= s_axis_tdata[63:0];
            count  <= s_axis_tdata[67:64];
            last   <= s_axis_tlast;
            state  <= s_axis_tuser ? S_INIT : S_BODY;
          end
        end
        S_INIT: begin
          if (mul_done) begin
            running_hash <= hash_seed ^ mul_product;
            state        <= S_BODY;
          end
        end
        S_BODY: begin
          if (count >= FULL_COUNT) begin
            state <= S_MIX1;
          end else if (count != '0) begin
            state <= S_HMUL;
          end else begin
            state <= S_END;
          end
        end
        S_MIX1: begin
          if (mul_done) begin
            state <= S_MIX2;
          end
        end
        S_MIX2: begin
          if (mul_done) begin
            state <= S_HMUL;
          end
        end
        S_HMUL: begin
          if (mul_done) begin
            running_hash <= mul_product;
            state        <= S_END;
          end
        end
        S_END: begin
          state <= last ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (mul_done) begin
            word  <= mixed;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_axis_tdata  <= word;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_start_free: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy)
    else $error("multiplier launched while busy");
  a_done_waited: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_INIT || state == S_MIX1 || state == S_MIX2 ||
                  state == S_HMUL || state == S_FIN))
    else $error("multiplier result with no step waiting for it");
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free) |=> (m_axis_tvalid && state == S_IDLE))
    else $error("result not moved into output register");
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !s_axis_tready)
    else $error("ready again right after a transfer");
  a_first_starts_mul: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && s_axis_tuser) |=> mul_busy)
    else $error("first word did not start the length multiply");
`endif

endmodule

// ===== design/m64a_mul.sv =====
// m64a_mul: low 64 bits of operand times the mix constant, one 32x32 product per cycle
// depends on m64a_pkg
`timescale 1ns / 1ps

module m64a_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [m64a_pkg::WORD_W-1:0]   operand,
  output logic                          busy,
  output logic                          done,
  output logic [m64a_pkg::WORD_W-1:0]   product
);
  import m64a_pkg::*;

  typedef enum logic [1:0] {
    STEP_LL,  // a_lo * m_lo, full width
    STEP_LH,  // a_lo * m_hi, low half into upper word
    STEP_HL   // a_hi * m_lo, low half into upper word
  } step_t;

  logic [WORD_W-1:0] a;
  logic [WORD_W-1:0] acc;
  step_t             step;
  logic [HALF_W-1:0] op_x;
  logic [HALF_W-1:0] op_y;
  logic [WORD_W-1:0] pp;

  always_comb begin
    op_x = (step == STEP_HL) ? a[WORD_W-1:HALF_W] : a[HALF_W-1:0];
    op_y = (step == STEP_LH) ? MIX_MUL[WORD_W-1:HALF_W] : MIX_MUL[HALF_W-1:0];
    pp   = WORD_W'(op_x) * WORD_W'(op_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= STEP_LL;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        step <= STEP_LL;
        a    <= operand;
      end else if (busy) begin
        case (step)
          STEP_LL: begin
            acc  <= pp;
            step <= STEP_LH;
          end
          STEP_LH: begin
            acc[WORD_W-1:HALF_W] <= acc[WORD_W-1:HALF_W] + pp[HALF_W-1:0];
            step <= STEP_HL;
          end
          STEP_HL: begin
            acc[WORD_W-1:HALF_W] <= acc[WORD_W-1:HALF_W] + pp[HALF_W-1:0];
            busy <= 1'b0;
            done <= 1'b1;
            step <= STEP_LL;
          end
          default: begin
            busy <= 1'b0;
            step <= STEP_LL;
          end
        endcase
      end
    end
  end

  assign product = acc;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("multiplier done while still busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("multiplier done without a run");
  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> step == STEP_LL)
    else $error("multiplier step not reset when idle");
`endif

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for murmur64a_stream_hash (streaming MurmurHash64A)
// depends on m64a_pkg for widths and the mix multiplier; drives the block and checks every hash
`timescale 1ns / 1ps

module tb_top;

  import m64a_pkg::*;

  localparam int unsigned WORD_TARGET = 1900;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned IDLE_HOLD   = 40;      // longer than the slowest word in work

  // one input transfer, split into its fields
  typedef struct {
    logic [WORD_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    logic               first;
    logic               last;
    logic [LEN_W-1:0]   len;
  } hash_word_t;

  // running-hash predictor plus the queue of hashes still owed by the block
  class hash_scoreboard;
    logic [WORD_W-1:0] seed;
    logic [WORD_W-1:0] running;
    logic [WORD_W-1:0] expected_hashes[$];
    int                errors;

    function new();
      seed    = '0;
      running = '0;
      errors  = 0;
    endfunction

    function automatic logic [WORD_W-1:0] scramble(input logic [WORD_W-1:0] k);
      logic [WORD_W-1:0] v;
      v = k * MIX_MUL;
      v = v ^ (v >> 47);
      v = v * MIX_MUL;
      return v;
    endfunction

    function automatic logic [WORD_W-1:0] avalanche(input logic [WORD_W-1:0] h);
      logic [WORD_W-1:0] v;
      v = h ^ (h >> 47);
      v = v * MIX_MUL;
      v = v ^ (v >> 47);
      return v;
    endfunction

    function void set_seed(input logic [WORD_W-1:0] value);
      seed = value;
    endfunction

    // fold one accepted word into the running hash; a closing word owes a hash
    function void note_word(input hash_word_t w);
      logic [WORD_W-1:0] h;
      logic [WORD_W-1:0] keep;
      h = running;
      if (w.first) begin
        h = seed ^ ({32'h0, w.len} * MIX_MUL);
      end
      if (w.count >= 4'd8) begin
        h = (h ^ scramble(w.data)) * MIX_MUL;
      end else if (w.count != 4'd0) begin
        keep = {WORD_W{1'b1}} >> (WORD_W - 8 * w.count);
        h = (h ^ (w.data & keep)) * MIX_MUL;
      end
      running = h;
      if (w.last) begin
        expected_hashes = {expected_hashes, avalanche(h)};
      end
    endfunction

    function void check_hash(input logic [WORD_W-1:0] actual);
      logic [WORD_W-1:0] want;
      if (expected_hashes.size() == 0) begin
        $error("hash_value transfer with nothing outstanding: actual %h", actual);
        errors++;
      end else begin
        want = expected_hashes.pop_front();
        if (want !== actual) begin
          $error("hash_value mismatch: expected %h, actual %h", want, actual);
          errors++;
        end
      end
    endfunction

    function int outstanding();
      return expected_hashes.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    cfg_wr_en;
  logic [WORD_W-1:0]       cfg_wr_data;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata;   // data_word, byte_count, total_length, zero pad
  logic                    s_axis_tuser;   // first_item
  logic                    s_axis_tlast;   // last_item
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;   // hash_value

  hash_scoreboard sb;
  bit             quiet;        // no gaps on either side while set
  int unsigned    words_sent;
  int unsigned    cycles;

  murmur64a_stream_hash dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic hash_word_t mk_word(input logic [WORD_W-1:0] data,
                                         input logic [COUNT_W-1:0] count,
                                         input logic first, input logic last,
                                         input logic [LEN_W-1:0] len);
    hash_word_t w;
    w.data  = data;
    w.count = count;
    w.first = first;
    w.last  = last;
    w.len   = len;
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] rand_data();
    return {$urandom(), $urandom()};
  endfunction

  // hold tvalid with the word until the block takes it
  task automatic send_word(input hash_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'h0, w.len, w.count, w.data};
    s_axis_tuser  <= w.first;
    s_axis_tlast  <= w.last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_word(w);
    words_sent++;
  endtask

  // well-formed message: full words, then a tail or (sometimes) an empty closing word
  task automatic send_message(input int unsigned len);
    int unsigned full;
    int unsigned rem;
    bit          empty_close;
    full        = len / 8;
    rem         = len % 8;
    empty_close = (rem == 0) && (len == 0 || $urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < full; i++) begin
      send_word(mk_word(rand_data(), 4'd8, i == 0,
                        (i == full - 1) && rem == 0 && !empty_close, len));
    end
    if (rem != 0 || empty_close) begin
      send_word(mk_word(rand_data(), COUNT_W'(rem), full == 0, 1'b1, len));
    end
  endtask

  // seed writes only with the block drained and settled
  task automatic write_seed(input logic [WORD_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (IDLE_HOLD) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_seed(value);
  endtask

  // result side: random stalls, none while quiet
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // every accepted result transfer goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_hash(m_axis_tdata);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned target;
    int          r;
    logic [WORD_W-1:0] seeds[5];

    sb            = new();
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    quiet         = 1'b1;
    words_sent    = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, reset seed of zero
    // word without a first right after reset continues from a zero hash
    send_word(mk_word({WORD_W{1'b1}}, 4'd8, 1'b0, 1'b1, 32'h0));
    // after a result the running hash carries on unfinalized
    send_word(mk_word(64'h0123_4567_89ab_cdef, 4'd1, 1'b0, 1'b1, 32'h0));
    // zero-length message, one empty word that opens and closes
    send_word(mk_word({WORD_W{1'b1}}, 4'd0, 1'b1, 1'b1, 32'h0));
    // opening and closing on one tail word
    send_word(mk_word(rand_data(), 4'd3, 1'b1, 1'b1, 32'd3));
    send_word(mk_word({WORD_W{1'b1}}, 4'd7, 1'b1, 1'b1, 32'd7));
    // counts above eight act as full words, longest length field
    send_word(mk_word({WORD_W{1'b1}}, 4'd15, 1'b1, 1'b0, {LEN_W{1'b1}}));
    // tail that does not close the message
    send_word(mk_word(64'h0, 4'd5, 1'b0, 1'b0, 32'h0));
    send_word(mk_word(rand_data(), 4'd9, 1'b0, 1'b1, 32'h0));
    // multiple of eight closed by an empty word
    send_word(mk_word(rand_data(), 4'd8, 1'b1, 1'b0, 32'd16));
    send_word(mk_word(rand_data(), 4'd8, 1'b0, 1'b0, 32'd16));
    send_word(mk_word(rand_data(), 4'd0, 1'b0, 1'b1, 32'd16));
    // length that disagrees with the byte counts
    send_word(mk_word(rand_data(), 4'd2, 1'b1, 1'b1, 32'd100));
    send_word(mk_word(64'h8000_0000_0000_0001, 4'd4, 1'b1, 1'b1, 32'hffff_fff0));
    // all byte counts once
    for (int c = 0; c < 16; c++) begin
      send_word(mk_word(rand_data(), COUNT_W'(c), 1'b0, c[0], $urandom()));
    end

    // random part, phases under different seeds including the extremes
    seeds[0] = {WORD_W{1'b1}};
    seeds[1] = rand_data();
    seeds[2] = 64'h1;
    seeds[3] = 64'h8000_0000_0000_0000;
    seeds[4] = 64'h0;
    target   = words_sent;
    for (int ph = 0; ph < 5; ph++) begin
      write_seed(seeds[ph]);
      quiet  = (ph == 2);
      target = target + WORD_TARGET / 5;
      while (words_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          send_message($urandom_range(0, 24));
        end else if (r < 75) begin
          send_message($urandom_range(25, 64));
        end else if (r < 82) begin
          send_message($urandom_range(65, 200));
        end else begin
          // noise: any field value, including broken message framing
          repeat ($urandom_range(1, 3)) begin
            send_word(mk_word(rand_data(), COUNT_W'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              $urandom()));
          end
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain, then let the block settle
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (IDLE_HOLD) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
